// ===== rtl/core/iee_pkg.sv =====
package iee_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 48;

    localparam logic [2:0] FUNC_NUM    = 3'd0;
    localparam logic [2:0] FUNC_OP     = 3'd1;
    localparam logic [2:0] FUNC_LPAREN = 3'd2;
    localparam logic [2:0] FUNC_RPAREN = 3'd3;
    localparam logic [2:0] FUNC_END    = 3'd4;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [2:0] TOK_LPAREN = 3'd4;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_DIV0   = 2'd1;
    localparam logic [1:0] ERR_STACK  = 2'd2;
    localparam logic [1:0] ERR_PAREN  = 2'd3;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  op_code;
        logic [15:0] number;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    error;
        logic [1:0]              error_kind;
    } t_out;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic div0;
    } t_alu_sts;

endpackage

// ===== rtl/core/iee_alu.sv =====
module iee_alu (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  iee_pkg::t_alu_req           i_req,
    input  logic signed [47:0]          i_a,
    input  logic signed [47:0]          i_b,
    output iee_pkg::t_alu_sts           o_sts,
    output logic signed [47:0]          o_res
);
    import iee_pkg::*;

    localparam int QW = 2 * VAL_W;          // mul product / div quotient width
    localparam int DN = VAL_W + FRAC_BITS;  // dividend bits
    localparam int IW = $clog2(DN + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]         r_st, n_st;
    logic [1:0]         r_op;
    logic               r_neg;
    logic [VAL_W-1:0]   r_ma, r_mb;
    logic [QW-1:0]      r_acc;
    logic [VAL_W:0]     r_rem;
    logic [DN-1:0]      r_dvd;
    logic [IW-1:0]      r_cnt;
    logic [1:0]         r_part;
    logic               r_div0;
    logic signed [VAL_W-1:0] r_res;

    logic [VAL_W-1:0] ma_c, mb_c;
    logic [VAL_W+1:0] sum_c;
    logic [VAL_W:0]   rem_sh;
    logic [VAL_W:0]   rem_sub;
    logic [23:0]      a_part;
    logic [QW-1:0]    pp;
    logic [QW-1:0]    shifted;
    logic             over;
    logic [QW-1:0]    mag_fin;

    assign ma_c = i_a[VAL_W-1] ? (VAL_W)'(-i_a) : i_a;
    assign mb_c = i_b[VAL_W-1] ? (VAL_W)'(-i_b) : i_b;
    assign sum_c = (i_req.op == OP_ADD) ? {{2{i_a[VAL_W-1]}}, i_a} + {{2{i_b[VAL_W-1]}}, i_b}
                                        : {{2{i_a[VAL_W-1]}}, i_a} - {{2{i_b[VAL_W-1]}}, i_b};

    // multiply: 24x48 partial product per cycle, low then high 24 bits of a
    assign a_part = r_part[0] ? r_ma[47:24] : r_ma[23:0];
    assign pp = QW'(a_part * r_mb) << (r_part[0] ? 24 : 0);

    // restoring divide one quotient bit per cycle
    assign rem_sh  = {r_rem[VAL_W-1:0], r_dvd[DN-1]};
    assign rem_sub = rem_sh - {1'b0, r_mb};

    assign shifted = (r_op == OP_MUL) ? (r_acc >> FRAC_BITS) : r_acc;
    assign over    = (r_op == OP_MUL) ? (r_acc[QW-1:VAL_W+FRAC_BITS] != '0)
                                      : (r_acc[QW-1:VAL_W] != '0);
    assign mag_fin = shifted;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_req.start) begin
                case (i_req.op)
                    OP_MUL:  n_st = S_MUL;
                    OP_DIV:  n_st = (mb_c == '0) ? S_DONE : S_DIV;
                    default: n_st = S_DONE;
                endcase
            end
            S_MUL:   if (r_part == 2'd1) n_st = S_FIN;
            S_DIV:   if (r_cnt == IW'(DN - 1)) n_st = S_FIN;
            S_FIN:   n_st = S_DONE;
            S_DONE:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: if (i_req.start) begin
                r_op   <= i_req.op;
                r_ma   <= ma_c;
                r_mb   <= mb_c;
                r_neg  <= i_a[VAL_W-1] ^ i_b[VAL_W-1];
                r_acc  <= '0;
                r_rem  <= '0;
                r_dvd  <= {ma_c, {FRAC_BITS{1'b0}}};
                r_cnt  <= '0;
                r_part <= '0;
                r_div0 <= (i_req.op == OP_DIV) && (mb_c == '0);
                if (i_req.op == OP_DIV)
                    r_res <= '0;
                else if (sum_c[VAL_W+1] && !(&sum_c[VAL_W:VAL_W-1]))
                    r_res <= VAL_MIN;
                else if (!sum_c[VAL_W+1] && (|sum_c[VAL_W:VAL_W-1]))
                    r_res <= VAL_MAX;
                else
                    r_res <= sum_c[VAL_W-1:0];
            end
            S_MUL: begin
                r_acc  <= r_acc + pp;
                r_part <= r_part + 2'd1;
            end
            S_DIV: begin
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 1'b1;
                if (rem_sh >= {1'b0, r_mb}) begin
                    r_rem <= rem_sub;
                    r_acc <= {r_acc[QW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_acc <= {r_acc[QW-2:0], 1'b0};
                end
            end
            S_FIN: begin
                if (r_neg) begin
                    if (over || mag_fin[VAL_W-1:0] >= VAL_MIN)
                        r_res <= VAL_MIN;
                    else
                        r_res <= -$signed(mag_fin[VAL_W-1:0]);
                end else begin
                    if (over || mag_fin[VAL_W-1])
                        r_res <= VAL_MAX;
                    else
                        r_res <= mag_fin[VAL_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_sts.done = (r_st == S_DONE);
    assign o_sts.div0 = r_div0;
    assign o_res      = r_res;
endmodule

// ===== rtl/core/infix_expression_evaluator_unit.sv =====
// Shunting-yard evaluator: one token per transfer, results only on an end token.
// Number, left paren and unused kinds pass through S_TOK and then are ready. An operator,
// right paren or end token spends a read and a compare (S_OPRD, S_OPCHK) on each operator
// stack entry it looks at. Each operator applied adds value stack reads (S_VRD1, S_VRD2)
// and a pass through the shared arithmetic unit: add, subtract or divide by zero go
// straight to done, multiply forms two 24x48 partial products, divide makes one quotient
// bit per cycle over 64 bits. Pushing an operator adds S_PUSH; an end token adds S_ENDRD
// and S_EMIT (top value read, result load). The block is not ready while a token works.
// A finished result waits in an output register while further tokens enter; the next end
// token holds in its last step until that result has been taken.
module infix_expression_evaluator_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  iee_pkg::t_in    i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output iee_pkg::t_out   o_data
);
    import iee_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TOK   = 4'd1;
    localparam logic [3:0] S_OPRD  = 4'd2;
    localparam logic [3:0] S_OPCHK = 4'd3;
    localparam logic [3:0] S_VRD1  = 4'd4;
    localparam logic [3:0] S_VRD2  = 4'd5;
    localparam logic [3:0] S_ALU   = 4'd6;
    localparam logic [3:0] S_WAIT  = 4'd7;
    localparam logic [3:0] S_PUSH  = 4'd8;
    localparam logic [3:0] S_ENDRD = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic [3:0]       r_st;
    t_in              r_tok;
    logic [CNT_W-1:0] r_ocnt, r_vcnt;
    logic [1:0]       r_err;
    logic [2:0]       r_top;        // op popped for application
    logic [2:0]       r_ord;
    logic [VAL_W-1:0] r_vrd;
    logic [VAL_W-1:0] r_va, r_vb;
    logic             r_ov;
    t_out             r_out;

    logic [2:0]       ostk [STACK_DEPTH];
    logic [VAL_W-1:0] vstk [STACK_DEPTH];

    t_alu_req         alu_req;
    t_alu_sts         alu_sts;
    logic signed [VAL_W-1:0] alu_res;

    logic [SP_W-1:0] otop_a, vtop_a;
    assign otop_a = SP_W'(r_ocnt - 1'b1);
    assign vtop_a = SP_W'(r_vcnt - 1'b1);

    function automatic logic [1:0] sticky(input logic [1:0] cur, input logic [1:0] k);
        sticky = (cur == ERR_NONE) ? k : cur;
    endfunction

    // operator stack read, registered
    logic [SP_W-1:0] ord_a;
    assign ord_a = otop_a;
    always_ff @(posedge i_clk) begin
        r_ord <= ostk[ord_a];
    end

    // value stack: one read port, one write port
    logic             v_we, o_we;
    logic [SP_W-1:0]  v_wa, o_wa, v_ra;
    logic [VAL_W-1:0] v_wd;
    logic [2:0]       o_wd;
    always_ff @(posedge i_clk) begin
        if (v_we) vstk[v_wa] <= v_wd;
        if (o_we) ostk[o_wa] <= o_wd;
        r_vrd <= vstk[v_ra];
    end

    always_comb begin
        v_we = 1'b0; v_wa = r_vcnt[SP_W-1:0];
        v_wd = VAL_W'({r_tok.number, {FRAC_BITS{1'b0}}});
        o_we = 1'b0; o_wa = r_ocnt[SP_W-1:0]; o_wd = {1'b0, r_tok.op_code};
        v_ra = vtop_a;
        case (r_st)
            S_TOK: begin
                if (r_tok.func == FUNC_NUM && r_vcnt < CNT_W'(STACK_DEPTH)) v_we = 1'b1;
                if (r_tok.func == FUNC_LPAREN && r_ocnt < CNT_W'(STACK_DEPTH)) begin
                    o_we = 1'b1; o_wd = TOK_LPAREN;
                end
            end
            S_PUSH: if (r_tok.func == FUNC_OP && r_ocnt < CNT_W'(STACK_DEPTH)) o_we = 1'b1;
            S_VRD1: v_ra = SP_W'(r_vcnt - 2'd2);
            S_WAIT: if (alu_sts.done) begin
                v_we = 1'b1; v_wa = SP_W'(r_vcnt - 2'd2); v_wd = alu_res;
            end
            default: ;
        endcase
    end

    assign alu_req.start = (r_st == S_ALU);
    assign alu_req.op    = r_top[1:0];

    iee_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_va),
        .i_b     (r_vb),
        .o_sts   (alu_sts),
        .o_res   (alu_res)
    );

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    logic pop_stop;
    always_comb begin
        pop_stop = 1'b1;
        case (r_tok.func)
            FUNC_OP:     pop_stop = (r_ord == TOK_LPAREN) || (r_ord[1] < r_tok.op_code[1]);
            FUNC_RPAREN: pop_stop = (r_ord == TOK_LPAREN);
            default:     pop_stop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0;
            r_ocnt <= '0; r_vcnt <= '0; r_err <= ERR_NONE;
        end else begin
            // a result loaded in S_EMIT keeps the output valid
            if (o_valid && i_ready && r_st != S_EMIT) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (i_valid && o_ready) begin
                    r_tok <= i_data;
                    r_st  <= S_TOK;
                end
                S_TOK: begin
                    r_st <= S_IDLE;
                    case (r_tok.func)
                        FUNC_NUM: begin
                            if (r_vcnt < CNT_W'(STACK_DEPTH)) r_vcnt <= r_vcnt + 1'b1;
                            else r_err <= sticky(r_err, ERR_STACK);
                        end
                        FUNC_LPAREN: begin
                            if (r_ocnt < CNT_W'(STACK_DEPTH)) r_ocnt <= r_ocnt + 1'b1;
                            else r_err <= sticky(r_err, ERR_STACK);
                        end
                        FUNC_OP, FUNC_RPAREN, FUNC_END: begin
                            if (r_ocnt != '0) r_st <= S_OPRD;
                            else if (r_tok.func == FUNC_OP) r_st <= S_PUSH;
                            else if (r_tok.func == FUNC_RPAREN)
                                r_err <= sticky(r_err, ERR_PAREN);
                            else r_st <= S_ENDRD;
                        end
                        default: ;
                    endcase
                end
                S_OPRD: r_st <= S_OPCHK;   // stack read in flight
                S_OPCHK: begin
                    if (pop_stop) begin
                        if (r_tok.func == FUNC_OP) r_st <= S_PUSH;
                        else begin
                            r_ocnt <= r_ocnt - 1'b1;  // drop the matching paren
                            r_st <= S_IDLE;
                        end
                    end else begin
                        r_ocnt <= r_ocnt - 1'b1;
                        r_top  <= r_ord;
                        if (r_ord == TOK_LPAREN) begin
                            r_err <= sticky(r_err, ERR_PAREN);
                            r_st  <= (r_ocnt == CNT_W'(1)) ? S_ENDRD : S_OPRD;
                        end else if (r_vcnt < CNT_W'(2)) begin
                            r_err <= sticky(r_err, ERR_STACK);
                            if (r_ocnt != CNT_W'(1)) r_st <= S_OPRD;
                            else if (r_tok.func == FUNC_OP) r_st <= S_PUSH;
                            else if (r_tok.func == FUNC_END) r_st <= S_ENDRD;
                            else r_st <= S_IDLE;
                        end else begin
                            r_st <= S_VRD1;
                        end
                    end
                end
                S_VRD1: r_st <= S_VRD2;        // read of b issued in previous cycle
                S_VRD2: r_st <= S_ALU;
                S_ALU: r_st <= S_WAIT;
                S_WAIT: if (alu_sts.done) begin
                    r_vcnt <= r_vcnt - 1'b1;
                    if (r_ocnt != '0) r_st <= S_OPRD;
                    else if (r_tok.func == FUNC_OP) r_st <= S_PUSH;
                    else if (r_tok.func == FUNC_END) r_st <= S_ENDRD;
                    else r_st <= S_IDLE;
                    // right paren that emptied the stack without finding its match
                    if (r_ocnt == '0 && r_tok.func == FUNC_RPAREN)
                        r_err <= sticky(sticky(r_err, alu_sts.div0 ? ERR_DIV0 : ERR_NONE),
                                        ERR_PAREN);
                    else if (alu_sts.div0)
                        r_err <= sticky(r_err, ERR_DIV0);
                end
                S_PUSH: begin
                    if (r_ocnt < CNT_W'(STACK_DEPTH)) r_ocnt <= r_ocnt + 1'b1;
                    else r_err <= sticky(r_err, ERR_STACK);
                    r_st <= S_IDLE;
                end
                S_ENDRD: r_st <= S_EMIT;       // top value read in flight
                S_EMIT: if (!r_ov || i_ready) begin
                    r_ov <= 1'b1;
                    if (r_vcnt != '0) begin
                        r_out.value      <= r_vrd;
                        r_out.error      <= (r_err != ERR_NONE);
                        r_out.error_kind <= r_err;
                    end else begin
                        r_out.value      <= '0;
                        r_out.error      <= 1'b1;
                        r_out.error_kind <= sticky(r_err, ERR_STACK);
                    end
                    r_ocnt <= '0; r_vcnt <= '0; r_err <= ERR_NONE;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // a is read in the cycle after b's address; capture it here
    always_ff @(posedge i_clk) begin
        if (r_st == S_VRD2) r_va <= r_vrd;
    end

    // note: S_VRD1 addresses a (count-2); S_OPCHK default address is b (count-1)
    // so r_vrd holds b at S_VRD1 and a at S_VRD2

    always_ff @(posedge i_clk) begin
        if (r_st == S_VRD1) r_vb <= r_vrd;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= CNT_W'(STACK_DEPTH) && r_vcnt <= CNT_W'(STACK_DEPTH))
        else $error("stack count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> r_vcnt >= CNT_W'(2))
        else $error("operator applied with too few values");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_data.error == (o_data.error_kind != ERR_NONE)))
        else $error("error flag disagrees with kind");
endmodule
